@@ src/strided_2d_window_convolution_core_assert.svh @@
// Assertion macros for the strided 2D window convolution core.
// Needs clk and rst_n in the scope that uses them.
`ifndef STRIDED_2D_WINDOW_CONVOLUTION_CORE_ASSERT_SVH
`define STRIDED_2D_WINDOW_CONVOLUTION_CORE_ASSERT_SVH

// Same-cycle implication.
`define S2WC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s2wc assertion failed");

// Next-cycle implication.
`define S2WC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s2wc assertion failed");

`endif

@@ src/s2wc_pkg.sv @@
// Shared types and constants of the strided 2D window convolution core.
// No dependencies.
package s2wc_pkg;

    localparam int SPAN          = 3;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MAX_STRIDE    = 8;
    localparam int PIX_W         = 24;
    localparam int PSUM_W        = 27;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 6;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_STRIDE = 3'd2;
    localparam logic [2:0] REG_COLOR  = 3'd3;
    localparam logic [2:0] REG_COEF_A = 3'd4;
    localparam logic [2:0] REG_COEF_B = 3'd5;
    localparam logic [2:0] REG_COEF_C = 3'd6;

    localparam logic [10:0] WIDTH_RST  = 11'd640;
    localparam logic [10:0] HEIGHT_RST = 11'd480;
    localparam logic [3:0]  STRIDE_RST = 4'd1;

    typedef logic [SPAN-1:0][PIX_W-1:0]  col_t;
    typedef logic [SPAN-1:0][15:0]       tapcol_t;
    typedef logic [2:0][PSUM_W-1:0]      psum3_t;

    typedef struct packed {
        logic shift;
        logic clr;
    } cell_ctl_t;

    typedef struct packed {
        logic       emit;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
        logic       eof;
    } meta_t;

endpackage

@@ src/s2wc_line_buf.sv @@
// Two-row line store of the convolution core, one read and one write per cycle.
// Depends on s2wc_pkg.
module s2wc_line_buf
    import s2wc_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [2*PIX_W-1:0]       wr_data,
    output logic [2*PIX_W-1:0]       rd_data
);

    logic [2*PIX_W-1:0] mem [DEPTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic               fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg       <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_reg;

endmodule

@@ src/s2wc_col_cell.sv @@
// One window column cell: holds a column of samples, passes it on, and
// forms the registered column partial sums per channel. Depends on s2wc_pkg.
module s2wc_col_cell
    import s2wc_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  col_t      d_in,
    input  tapcol_t   taps,
    output col_t      q,
    output psum3_t    psum
);

    col_t   col_reg;
    psum3_t psum_reg;
    psum3_t psum_next;

    always_comb
    begin
        logic signed [PSUM_W-1:0] acc;
        logic signed [24:0]       prod;
        psum_next = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = '0;
            for (int u = 0; u < SPAN; u++)
            begin
                prod = $signed({1'b0, col_reg[u][8*ch +: 8]}) * $signed(taps[u]);
                acc  = acc + PSUM_W'(prod);
            end
            psum_next[ch] = acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            col_reg <= ctl.clr ? '0 : d_in;
        end
        psum_reg <= psum_next;
    end

    assign q    = col_reg;
    assign psum = psum_reg;

endmodule

@@ src/strided_2d_window_convolution_core.sv @@
// Path: a result passes stage A, the column cells and their registered partial sums,
// then the output queue; the extra result at a row end comes after it, from a zero column.
// Throughput: one item per cycle; an item ending a row that yields a second result
// holds input while a zero column shifts through the column cells.
// Input also holds while eight or more results wait in the 16-entry output queue.
// Reset: registers to defaults, position to row 0 column 0; line store needs no clearing.
module strided_2d_window_convolution_core
    import s2wc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [7:0]            pix_a,
    input  logic [7:0]            pix_b,
    input  logic [7:0]            pix_c,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            res_a,
    output logic [7:0]            res_b,
    output logic [7:0]            res_c,
    output logic [9:0]            out_row,
    output logic [9:0]            out_col,
    output logic                  last_of_run,
    output logic                  end_of_frame
);

    localparam int AW         = $clog2(MAX_WIDTH);
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = 4;
    localparam int FIFO_HOLD  = 8;
    localparam int TOT_W      = PSUM_W + 2;

    typedef struct packed {
        logic [7:0] ra;
        logic [7:0] rb;
        logic [7:0] rc;
        meta_t      m;
    } res_t;

    // configuration
    logic [10:0] width_reg, height_reg;
    logic [3:0]  stride_reg;
    logic        color_reg;
    logic [63:0] coef_a_reg, coef_b_reg, coef_c_reg;
    logic        cfg_wr, geom_wr;
    logic [10:0] wd, h;
    logic [3:0]  s;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign geom_wr = cfg_wr && (paddr[5:3] == REG_WIDTH || paddr[5:3] == REG_HEIGHT ||
                                paddr[5:3] == REG_STRIDE || paddr[5:3] == REG_COLOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            stride_reg <= STRIDE_RST;
            color_reg  <= 1'b1;
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[10:0];
                REG_STRIDE: stride_reg <= pwdata[3:0];
                REG_COLOR:  color_reg  <= pwdata[0];
                REG_COEF_A: coef_a_reg <= pwdata;
                REG_COEF_B: coef_b_reg <= pwdata;
                REG_COEF_C: coef_c_reg <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            REG_WIDTH:  prdata = 64'(width_reg);
            REG_HEIGHT: prdata = 64'(height_reg);
            REG_STRIDE: prdata = 64'(stride_reg);
            REG_COLOR:  prdata = 64'(color_reg);
            REG_COEF_A: prdata = coef_a_reg;
            REG_COEF_B: prdata = coef_b_reg;
            REG_COEF_C: prdata = coef_c_reg;
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        if (width_reg == 11'd0)
            wd = 11'd1;
        else if (width_reg > 11'(MAX_WIDTH))
            wd = 11'(MAX_WIDTH);
        else
            wd = width_reg;
        if (height_reg == 11'd0)
            h = 11'd1;
        else if (height_reg > 11'(MAX_HEIGHT))
            h = 11'(MAX_HEIGHT);
        else
            h = height_reg;
        if (stride_reg == 4'd0)
            s = 4'd1;
        else if (stride_reg > 4'(MAX_STRIDE))
            s = 4'(MAX_STRIDE);
        else
            s = stride_reg;
    end

    // position tracking
    logic [10:0]   in_row_reg;
    logic [AW-1:0] in_col_reg;
    logic [3:0]    ic_mod_reg, pc_mod_reg, ir_mod_reg, pr_mod_reg;
    logic [9:0]    ic_div_reg, pc_div_reg, pr_div_reg;
    logic [10:0]   ir_div_reg;
    logic          in_acc, ic_last, row_ok, emit_n, emit_x, row_eof;
    logic [11:0]   col_end_sum;
    logic [4:0]    fifo_cnt_reg;

    logic          a_valid_reg, a_ex_reg, a_ge1_reg, a_ge2_reg, a_clr_reg;
    logic [PIX_W-1:0] a_pix_reg;
    logic [AW-1:0] a_addr_reg;
    meta_t         a_meta_n_reg, a_meta_x_reg;

    assign in_stall = (a_valid_reg && a_ex_reg) || (fifo_cnt_reg >= 5'(FIFO_HOLD));
    assign in_acc   = in_valid && !in_stall;
    assign ic_last  = (11'(in_col_reg) == wd - 11'd1);
    assign row_ok   = (in_row_reg != 11'd0) && (pr_mod_reg == 4'd0);
    assign emit_n   = row_ok && (in_col_reg != '0) && (pc_mod_reg == 4'd0);
    assign emit_x   = row_ok && ic_last && (ic_mod_reg == 4'd0);
    assign row_eof  = (12'(in_row_reg) + 12'(s)) > 12'(h);
    assign col_end_sum = 12'(in_col_reg) + 12'(s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
            ic_mod_reg <= '0;
            ic_div_reg <= '0;
            pc_mod_reg <= '0;
            pc_div_reg <= '0;
            ir_mod_reg <= '0;
            ir_div_reg <= '0;
            pr_mod_reg <= '0;
            pr_div_reg <= '0;
        end
        else if (geom_wr)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
            ic_mod_reg <= '0;
            ic_div_reg <= '0;
            ir_mod_reg <= '0;
            ir_div_reg <= '0;
        end
        else if (in_acc)
        begin
            pc_mod_reg <= ic_mod_reg;
            pc_div_reg <= ic_div_reg;
            if (ic_last)
            begin
                in_col_reg <= '0;
                ic_mod_reg <= '0;
                ic_div_reg <= '0;
                pr_mod_reg <= ir_mod_reg;
                pr_div_reg <= ir_div_reg[9:0];
                if (in_row_reg >= h)
                begin
                    in_row_reg <= '0;
                    ir_mod_reg <= '0;
                    ir_div_reg <= '0;
                end
                else
                begin
                    in_row_reg <= in_row_reg + 11'd1;
                    if (ir_mod_reg + 4'd1 == s)
                    begin
                        ir_mod_reg <= '0;
                        ir_div_reg <= ir_div_reg + 11'd1;
                    end
                    else
                    begin
                        ir_mod_reg <= ir_mod_reg + 4'd1;
                    end
                end
            end
            else
            begin
                in_col_reg <= in_col_reg + AW'(1);
                if (ic_mod_reg + 4'd1 == s)
                begin
                    ic_mod_reg <= '0;
                    ic_div_reg <= ic_div_reg + 10'd1;
                end
                else
                begin
                    ic_mod_reg <= ic_mod_reg + 4'd1;
                end
            end
        end
    end

    // stage A: item taken, line store read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_ex_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_acc;
            a_ex_reg    <= in_acc && emit_x;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_pix_reg  <= (!op && in_row_reg < h) ? {pix_c, pix_b, pix_a} : '0;
            a_ge1_reg  <= in_row_reg != 11'd0;
            a_ge2_reg  <= in_row_reg >= 11'd2;
            a_clr_reg  <= in_col_reg == '0;
            a_addr_reg <= in_col_reg;
            a_meta_n_reg <= '{emit: emit_n, row: pr_div_reg, col: pc_div_reg,
                              last: !emit_x, eof: row_eof && (col_end_sum > 12'(wd))};
            a_meta_x_reg <= '{emit: emit_x, row: pr_div_reg, col: ic_div_reg,
                              last: 1'b1, eof: row_eof && (col_end_sum >= 12'(wd))};
        end
    end

    // line store
    logic [2*PIX_W-1:0] lb_rd;
    logic [PIX_W-1:0]   ls0, ls1;
    col_t               new_col;

    s2wc_line_buf #(.DEPTH(MAX_WIDTH)) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (in_col_reg),
        .wr_en   (a_valid_reg),
        .wr_addr (a_addr_reg),
        .wr_data ({ls0, a_pix_reg}),
        .rd_data (lb_rd)
    );

    assign ls0 = lb_rd[PIX_W-1:0];
    assign ls1 = lb_rd[2*PIX_W-1:PIX_W];
    assign new_col[2] = a_pix_reg;
    assign new_col[1] = a_ge1_reg ? ls0 : '0;
    assign new_col[0] = a_ge2_reg ? ls1 : '0;

    // window: chain of column cells, oldest column in cell 0
    logic      x_pend_reg;
    meta_t     x_meta_reg;
    logic      w_emit_reg, c_emit_reg;
    meta_t     w_meta_reg, c_meta_reg;
    cell_ctl_t ctl_lo, ctl_hi;
    col_t      q0, q1, q2;
    psum3_t    ps0, ps1, ps2;
    tapcol_t   taps0, taps1, taps2;

    assign ctl_lo = '{shift: a_valid_reg || x_pend_reg, clr: a_valid_reg && a_clr_reg};
    assign ctl_hi = '{shift: a_valid_reg || x_pend_reg, clr: 1'b0};

    assign taps0 = {coef_b_reg[47:32], coef_a_reg[63:48], coef_a_reg[15:0]};
    assign taps1 = {coef_b_reg[63:48], coef_b_reg[15:0],  coef_a_reg[31:16]};
    assign taps2 = {coef_c_reg[15:0],  coef_b_reg[31:16], coef_a_reg[47:32]};

    s2wc_col_cell u_cell0 (.clk(clk), .ctl(ctl_lo), .d_in(q1), .taps(taps0), .q(q0), .psum(ps0));
    s2wc_col_cell u_cell1 (.clk(clk), .ctl(ctl_lo), .d_in(q2), .taps(taps1), .q(q1), .psum(ps1));
    s2wc_col_cell u_cell2 (.clk(clk), .ctl(ctl_hi), .d_in(a_valid_reg ? new_col : '0),
                           .taps(taps2), .q(q2), .psum(ps2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pend_reg <= 1'b0;
            w_emit_reg <= 1'b0;
            c_emit_reg <= 1'b0;
        end
        else
        begin
            x_pend_reg <= a_valid_reg && a_ex_reg;
            w_emit_reg <= a_valid_reg ? a_meta_n_reg.emit : (x_pend_reg && x_meta_reg.emit);
            c_emit_reg <= w_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            x_meta_reg <= a_meta_x_reg;
        end
        w_meta_reg <= a_valid_reg ? a_meta_n_reg : x_meta_reg;
        c_meta_reg <= w_meta_reg;
    end

    // round, saturate, queue
    function automatic logic [7:0] sat8(input logic signed [TOT_W-1:0] v);
        logic signed [TOT_W-1:0] r;
        r = (v + TOT_W'(128)) >>> 8;
        if (v <= 0)
            return 8'd0;
        else if (r > TOT_W'(255))
            return 8'd255;
        else
            return r[7:0];
    endfunction

    logic signed [TOT_W-1:0] tot [3];
    res_t res_in;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            tot[ch] = TOT_W'($signed(ps0[ch])) + TOT_W'($signed(ps1[ch]))
                    + TOT_W'($signed(ps2[ch]));
        end
        res_in.ra = sat8(tot[0]);
        res_in.rb = color_reg ? sat8(tot[1]) : 8'd0;
        res_in.rc = color_reg ? sat8(tot[2]) : 8'd0;
        res_in.m  = c_meta_reg;
    end

    res_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic               pop;
    res_t               head;

    assign pop  = out_valid && !out_stall;
    assign head = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (c_emit_reg)
        begin
            fifo_mem[wr_ptr_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (c_emit_reg)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            fifo_cnt_reg <= fifo_cnt_reg + 5'(c_emit_reg) - 5'(pop);
        end
    end

    assign out_valid    = fifo_cnt_reg != 5'd0;
    assign res_a        = head.ra;
    assign res_b        = head.rb;
    assign res_c        = head.rc;
    assign out_row      = head.m.row;
    assign out_col      = head.m.col;
    assign last_of_run  = head.m.last;
    assign end_of_frame = head.m.eof;

`include "strided_2d_window_convolution_core_assert.svh"

    `S2WC_ASSERT_IMP(a_fifo_bound, 1'b1, fifo_cnt_reg <= 5'(FIFO_DEPTH))
    `S2WC_ASSERT_IMP(a_push_room, c_emit_reg, fifo_cnt_reg < 5'(FIFO_DEPTH))
    `S2WC_ASSERT_IMP(a_no_x_overlap, x_pend_reg, !a_valid_reg)
    `S2WC_ASSERT_NXT(a_x_follows, a_valid_reg && a_ex_reg, x_pend_reg)
    `S2WC_ASSERT_IMP(a_col_range, 1'b1, 11'(in_col_reg) < wd)

endmodule
